@@ sv/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

@@ sv/mexp_pkg.sv @@
// Shared types and codes for the modular exponentiation block.
`timescale 1ns / 1ps
`default_nettype none
package mexp_pkg;

    localparam int FIELD_W = 32;

    localparam logic [1:0] OP_REDUCE = 2'd0;
    localparam logic [1:0] OP_MUL    = 2'd1;
    localparam logic [1:0] OP_SQR    = 2'd2;

    localparam logic [1:0] OUT_ONE  = 2'd0;
    localparam logic [1:0] OUT_ZERO = 2'd1;
    localparam logic [1:0] OUT_RES  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       mul_start;
        logic       mul_step;
        logic       mul_wb;
        logic       exp_shift;
        logic       out_load;
        logic [1:0] op;
        logic [1:0] out_sel;
    } cmd_t;

    typedef struct packed {
        logic mod_zero;
        logic exp_in_zero;
        logic exp_bit0;
        logic exp_bit1;
    } sts_t;

endpackage
`default_nettype wire

@@ sv/mexp_datapath.sv @@
// Datapath: operand registers, modulus register and the shift-add modular multiplier.
`timescale 1ns / 1ps
`default_nettype none
module mexp_datapath
    import mexp_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wen,
    input  wire logic [FIELD_W-1:0]   cfg_wdata,
    input  wire logic [2*FIELD_W-1:0] s_tdata,
    input  wire cmd_t                 cmd,
    output sts_t                      sts,
    output logic [FIELD_W-1:0]        m_tdata
);

    logic [WIDTH+FIELD_W-1:0] base_ext, exp_ext, mod_ext;
    logic [WIDTH-1:0]         base_in, exp_in, mod_in;
    logic [FIELD_W+WIDTH-1:0] res_ext;
    logic [WIDTH-1:0]         modulus_reg, modulus_next;
    logic [WIDTH-1:0]         base_reg, base_next;
    logic [WIDTH-1:0]         exp_reg, exp_next;
    logic [WIDTH-1:0]         res_reg, res_next;
    logic [WIDTH-1:0]         acc_reg, acc_next;
    logic [WIDTH-1:0]         opa_reg, opa_next;
    logic [WIDTH-1:0]         opb_reg, opb_next;
    logic [FIELD_W-1:0]       out_reg, out_next;
    logic [WIDTH+1:0]         sum, m1, m2, diff1, diff2;
    logic [WIDTH-1:0]         acc_step;
    logic                     mod_one;

    assign base_ext = {{WIDTH{1'b0}}, s_tdata[FIELD_W-1:0]};
    assign exp_ext  = {{WIDTH{1'b0}}, s_tdata[2*FIELD_W-1:FIELD_W]};
    assign mod_ext  = {{WIDTH{1'b0}}, cfg_wdata};
    assign base_in  = base_ext[WIDTH-1:0];
    assign exp_in   = exp_ext[WIDTH-1:0];
    assign mod_in   = mod_ext[WIDTH-1:0];
    assign res_ext  = {{FIELD_W{1'b0}}, res_reg};

    assign mod_one = (modulus_reg == WIDTH'(1));

    assign sts.mod_zero    = (modulus_reg == '0);
    assign sts.exp_in_zero = (exp_in == '0);
    assign sts.exp_bit0    = exp_reg[0];
    assign sts.exp_bit1    = exp_reg[1];

    // one bit of b per cycle: acc = (2*acc + bit*a) mod m, sum stays below 3m
    always_comb begin
        m1    = {2'b00, modulus_reg};
        m2    = {1'b0, modulus_reg, 1'b0};
        sum   = {1'b0, acc_reg, 1'b0} + (opb_reg[WIDTH-1] ? {2'b00, opa_reg} : '0);
        diff1 = sum - m1;
        diff2 = sum - m2;
        priority if (sum >= m2) begin
            acc_step = diff2[WIDTH-1:0];
        end else if (sum >= m1) begin
            acc_step = diff1[WIDTH-1:0];
        end else begin
            acc_step = sum[WIDTH-1:0];
        end
    end

    always_comb begin
        modulus_next = cfg_wen ? mod_in : modulus_reg;
        base_next    = base_reg;
        exp_next     = exp_reg;
        res_next     = res_reg;
        acc_next     = acc_reg;
        opa_next     = opa_reg;
        opb_next     = opb_reg;
        out_next     = out_reg;
        if (cmd.load) begin
            base_next = base_in;
            exp_next  = exp_in;
            res_next  = mod_one ? '0 : WIDTH'(1);
        end
        if (cmd.mul_start) begin
            acc_next = '0;
            unique case (cmd.op)
                OP_REDUCE: begin
                    opa_next = WIDTH'(1);
                    opb_next = base_reg;
                end
                OP_MUL: begin
                    opa_next = res_reg;
                    opb_next = base_reg;
                end
                default: begin
                    opa_next = base_reg;
                    opb_next = base_reg;
                end
            endcase
        end
        if (cmd.mul_step) begin
            acc_next = acc_step;
            opb_next = {opb_reg[WIDTH-2:0], 1'b0};
        end
        if (cmd.mul_wb) begin
            if (cmd.op == OP_MUL) begin
                res_next = acc_reg;
            end else begin
                base_next = acc_reg;
            end
        end
        if (cmd.exp_shift) begin
            exp_next = {1'b0, exp_reg[WIDTH-1:1]};
        end
        if (cmd.out_load) begin
            unique case (cmd.out_sel)
                OUT_ONE:  out_next = FIELD_W'(1);
                OUT_ZERO: out_next = '0;
                default:  out_next = res_ext[FIELD_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= WIDTH'(1);
        end else begin
            modulus_reg <= modulus_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg <= base_next;
        exp_reg  <= exp_next;
        res_reg  <= res_next;
        acc_reg  <= acc_next;
        opa_reg  <= opa_next;
        opb_reg  <= opb_next;
        out_reg  <= out_next;
    end

    assign m_tdata = out_reg;

endmodule
`default_nettype wire

@@ sv/mexp_ctrl.sv @@
// Controller: sequences base reduction, multiply and square steps and the output beat.
`timescale 1ns / 1ps
`default_nettype none
module mexp_ctrl
    import mexp_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam int CW = $clog2(WIDTH);
    localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_WB    = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [1:0]    op_reg, op_next;
    logic [1:0]    sel_reg, sel_next;
    logic [CW-1:0] step_cnt_reg, step_cnt_next;
    logic [CW-1:0] bit_cnt_reg, bit_cnt_next;
    logic          out_valid_reg, out_valid_next;

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        sel_next      = sel_reg;
        step_cnt_next = step_cnt_reg;
        bit_cnt_next  = bit_cnt_reg;
        cmd           = '0;
        cmd.op        = op_reg;
        cmd.out_sel   = sel_reg;
        s_tready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    priority if (sts.exp_in_zero) begin
                        sel_next   = OUT_ONE;
                        state_next = ST_FIN;
                    end else if (sts.mod_zero) begin
                        sel_next   = OUT_ZERO;
                        state_next = ST_FIN;
                    end else begin
                        op_next    = OP_REDUCE;
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                cmd.mul_start = 1'b1;
                step_cnt_next = LAST;
                state_next    = ST_RUN;
            end
            ST_RUN: begin
                cmd.mul_step = 1'b1;
                if (step_cnt_reg == '0) begin
                    state_next = ST_WB;
                end else begin
                    step_cnt_next = step_cnt_reg - CW'(1);
                end
            end
            ST_WB: begin
                cmd.mul_wb = 1'b1;
                unique case (op_reg)
                    OP_REDUCE: begin
                        bit_cnt_next = LAST;
                        op_next      = sts.exp_bit0 ? OP_MUL : OP_SQR;
                        state_next   = ST_START;
                    end
                    OP_MUL: begin
                        op_next    = OP_SQR;
                        state_next = ST_START;
                    end
                    default: begin
                        cmd.exp_shift = 1'b1;
                        if (bit_cnt_reg == '0) begin
                            sel_next   = OUT_RES;
                            state_next = ST_FIN;
                        end else begin
                            bit_cnt_next = bit_cnt_reg - CW'(1);
                            op_next      = sts.exp_bit1 ? OP_MUL : OP_SQR;
                            state_next   = ST_START;
                        end
                    end
                endcase
            end
            ST_FIN: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        sel_reg      <= sel_next;
        step_cnt_reg <= step_cnt_next;
        bit_cnt_reg  <= bit_cnt_next;
    end

    assign m_tvalid = out_valid_reg;

endmodule
`default_nettype wire

@@ sv/modular_exponentiation.sv @@
// Top level of the modular exponentiation block: base^exponent mod modulus.
//
// Write the modulus through cfg_wen/cfg_wdata while the block is idle; it resets to 1.
// Each slave beat carries base and exponent; each master beat returns one power_mod.
// Work runs right to left over WIDTH exponent bits with one shared shift-add modular
// multiplier that retires one multiplier bit per cycle. For a nonzero exponent and modulus
// the work is one base reduction, then for each exponent bit a multiply when the bit is
// set and a squaring. A zero exponent gives result 1 and a zero modulus gives result 0.
// One item is in work at a time; s_tready is high only while no item is in work.
// The result sits in an output register, so the next item is taken while it waits.
// If m_tready stays low, a finished second result holds until the first beat leaves.
// Reset (aresetn low, synchronous) drops any item in work and any waiting result.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wen,
    input  wire logic [FIELD_W-1:0]   cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [2*FIELD_W-1:0] s_tdata,  // base [31:0], exponent [63:32]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [FIELD_W-1:0]        m_tdata   // power_mod [31:0]
);

    cmd_t       cmd;
    sts_t       sts;
    logic       in_accept;
    logic       out_blocked;
    logic [4:0] cmd_pulses;

    mexp_ctrl #(
        .WIDTH(WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mexp_datapath #(
        .WIDTH(WIDTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tdata  (m_tdata)
    );

    assign in_accept   = s_tvalid && s_tready;
    assign out_blocked = m_tvalid && !m_tready;
    assign cmd_pulses  = {cmd.load, cmd.mul_start, cmd.mul_step, cmd.mul_wb, cmd.out_load};

    `ASSERT_CLK(a_load_on_accept, aclk, aresetn, cmd.load == in_accept, "load without accept")
    `ASSERT_CLK(a_one_cmd, aclk, aresetn, $onehot0(cmd_pulses), "overlapping commands")
    `ASSERT_NEVER(a_out_overwrite, aclk, aresetn, cmd.out_load && out_blocked, "result overwritten")

endmodule
`default_nettype wire
